>>> hdl/fbc_pkg.sv
// ----------------------------------------------------------------------------
// fbc_pkg
// shared types and constants of the frustum box cull block: table sizes,
// datapath widths, opcodes, sequencer states and unit control words
// ----------------------------------------------------------------------------
`default_nettype none

package fbc_pkg;

  localparam int unsigned NumPlanes  = 6;
  localparam int unsigned NumCorners = 8;
  localparam int unsigned NumAxes    = 3;
  localparam int unsigned PlaneWords = 4;

  localparam int unsigned DataW = 32;
  localparam int unsigned ExtW  = DataW + 1;
  localparam int unsigned ProdW = DataW + ExtW;
  localparam int unsigned AccW  = ProdW + 3;
  localparam int unsigned FracW = 16;

  localparam int unsigned IdxW  = 3;
  localparam int unsigned AxisW = 2;

  typedef enum logic [1:0] {
    OP_WRITE_PLANE  = 2'd0,
    OP_WRITE_CORNER = 2'd1,
    OP_TEST_BOX     = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_PLANE = 2'd1,
    KIND_AXIS  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PINIT,
    ST_MUL,
    ST_ACC,
    ST_PCHK,
    ST_AXIS,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    ALU_HOLD,
    ALU_OFFSET,
    ALU_MUL,
    ALU_KEEP,
    ALU_ACC
  } alu_op_e;

  typedef struct packed {
    alu_op_e op;
  } alu_ctrl_t;

  typedef struct packed {
    logic acc_neg;
    logic above;
    logic below;
  } alu_stat_t;

  typedef struct packed {
    logic            plane_we;
    logic            corner_we;
    logic [IdxW-1:0] idx;
  } tbl_wr_t;

endpackage

`default_nettype wire

>>> hdl/fbc_tables.sv
// ----------------------------------------------------------------------------
// fbc_tables
// plane and corner tables: each write fills a whole item, one read port each
// ----------------------------------------------------------------------------
`default_nettype none

module fbc_tables (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire fbc_pkg::tbl_wr_t              wr_i,
  input  wire logic signed [fbc_pkg::DataW-1:0] wx_i,
  input  wire logic signed [fbc_pkg::DataW-1:0] wy_i,
  input  wire logic signed [fbc_pkg::DataW-1:0] wz_i,
  input  wire logic signed [fbc_pkg::DataW-1:0] woff_i,
  input  wire logic [fbc_pkg::IdxW-1:0]      plane_idx_i,
  input  wire logic [fbc_pkg::AxisW-1:0]     plane_word_i,
  input  wire logic [fbc_pkg::IdxW-1:0]      corner_idx_i,
  input  wire logic [fbc_pkg::AxisW-1:0]     corner_axis_i,
  output logic signed [fbc_pkg::DataW-1:0]   plane_rd_o,
  output logic signed [fbc_pkg::DataW-1:0]   corner_rd_o
);

  logic [fbc_pkg::DataW-1:0] plane_q  [fbc_pkg::NumPlanes][fbc_pkg::PlaneWords];
  logic [fbc_pkg::DataW-1:0] corner_q [fbc_pkg::NumCorners][fbc_pkg::NumAxes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < fbc_pkg::NumPlanes; p++) begin
        for (int w = 0; w < fbc_pkg::PlaneWords; w++) begin
          plane_q[p][w] <= '0;
        end
      end
      for (int c = 0; c < fbc_pkg::NumCorners; c++) begin
        for (int a = 0; a < fbc_pkg::NumAxes; a++) begin
          corner_q[c][a] <= '0;
        end
      end
    end else begin
      if (wr_i.plane_we) begin
        plane_q[wr_i.idx][0] <= wx_i;
        plane_q[wr_i.idx][1] <= wy_i;
        plane_q[wr_i.idx][2] <= wz_i;
        plane_q[wr_i.idx][3] <= woff_i;
      end
      if (wr_i.corner_we) begin
        corner_q[wr_i.idx][0] <= wx_i;
        corner_q[wr_i.idx][1] <= wy_i;
        corner_q[wr_i.idx][2] <= wz_i;
      end
    end
  end

  assign plane_rd_o  = plane_q[plane_idx_i][plane_word_i];
  assign corner_rd_o = corner_q[corner_idx_i][corner_axis_i];

endmodule

`default_nettype wire

>>> hdl/fbc_alu.sv
// ----------------------------------------------------------------------------
// fbc_alu
// shared arithmetic unit: one registered 32x33 multiply, a max-select
// accumulator for plane distances and the corner-against-face compares
// ----------------------------------------------------------------------------
`default_nettype none

module fbc_alu (
  input  wire logic                             clk_i,
  input  wire fbc_pkg::alu_ctrl_t               ctrl_i,
  input  wire logic signed [fbc_pkg::DataW-1:0] opa_i,
  input  wire logic signed [fbc_pkg::ExtW-1:0]  opb_i,
  input  wire logic signed [fbc_pkg::ExtW-1:0]  opc_i,
  output fbc_pkg::alu_stat_t                    stat_o
);

  logic signed [fbc_pkg::ProdW-1:0] prod_q, prod_d;
  logic signed [fbc_pkg::ProdW-1:0] lo_q;
  logic signed [fbc_pkg::ProdW-1:0] big;
  logic signed [fbc_pkg::AccW-1:0]  acc_q;
  logic signed [fbc_pkg::AccW-1:0]  off_ext;
  logic signed [fbc_pkg::ExtW-1:0]  opa_ext;

  assign prod_d  = opa_i * opb_i;
  assign big     = (prod_q > lo_q) ? prod_q : lo_q;
  assign off_ext = {{(fbc_pkg::AccW - fbc_pkg::DataW - fbc_pkg::FracW){opa_i[fbc_pkg::DataW-1]}},
                    opa_i, {fbc_pkg::FracW{1'b0}}};
  assign opa_ext = {opa_i[fbc_pkg::DataW-1], opa_i};

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      fbc_pkg::ALU_OFFSET: acc_q  <= off_ext;
      fbc_pkg::ALU_MUL:    prod_q <= prod_d;
      fbc_pkg::ALU_KEEP:   lo_q   <= prod_q;
      fbc_pkg::ALU_ACC:    acc_q  <= acc_q +
                             {{(fbc_pkg::AccW - fbc_pkg::ProdW){big[fbc_pkg::ProdW-1]}}, big};
      default: ;
    endcase
  end

  assign stat_o.acc_neg = acc_q[fbc_pkg::AccW-1];
  assign stat_o.above   = opa_ext > opb_i;
  assign stat_o.below   = opa_ext < opc_i;

endmodule

`default_nettype wire

>>> hdl/frustum_box_cull.sv
// ----------------------------------------------------------------------------
// frustum_box_cull
// culls axis-aligned boxes against six planes and eight frustum corners
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   operation .. max_z
//   out      output     out_valid_o / out_stall_i visible, reject_kind
//
// a table write leaves the block idle; a box test runs the accept,
// a distance check per plane on the single shared multiplier, a corner
// test step for each corner and axis and the posting of the word;
// a rejection ends the test early
// reset clears both tables to zero and drops any pending result word
// in_stall_o is high while a test runs or its word waits for a free output
// ----------------------------------------------------------------------------
`default_nettype none

module frustum_box_cull (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [1:0]                       operation_i,
  input  wire logic [fbc_pkg::IdxW-1:0]         entry_index_i,
  input  wire logic signed [fbc_pkg::DataW-1:0] x_value_i,
  input  wire logic signed [fbc_pkg::DataW-1:0] y_value_i,
  input  wire logic signed [fbc_pkg::DataW-1:0] z_value_i,
  input  wire logic signed [fbc_pkg::DataW-1:0] plane_offset_i,
  input  wire logic signed [fbc_pkg::DataW-1:0] min_x_i,
  input  wire logic signed [fbc_pkg::DataW-1:0] min_y_i,
  input  wire logic signed [fbc_pkg::DataW-1:0] min_z_i,
  input  wire logic signed [fbc_pkg::DataW-1:0] max_x_i,
  input  wire logic signed [fbc_pkg::DataW-1:0] max_y_i,
  input  wire logic signed [fbc_pkg::DataW-1:0] max_z_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic                                  visible_o,
  output logic [1:0]                            reject_kind_o
);

  fbc_pkg::state_e state_q, state_d;
  logic [fbc_pkg::IdxW-1:0]  p_q, p_d;
  logic [fbc_pkg::IdxW-1:0]  c_q, c_d;
  logic [fbc_pkg::AxisW-1:0] a_q, a_d;
  logic                      sel_q, sel_d;
  logic                      above_q, above_d;
  logic                      below_q, below_d;
  fbc_pkg::kind_e            kind_q, kind_d;

  logic                      out_valid_q;
  logic                      visible_q;
  fbc_pkg::kind_e            out_kind_q;
  logic                      post;

  logic signed [fbc_pkg::ExtW-1:0] pmn_q [fbc_pkg::NumAxes];
  logic signed [fbc_pkg::ExtW-1:0] pmx_q [fbc_pkg::NumAxes];

  logic                            accept;
  logic                            test_acc;
  fbc_pkg::tbl_wr_t                wr;
  fbc_pkg::alu_ctrl_t              alu_ctrl;
  fbc_pkg::alu_stat_t              alu_stat;
  logic [fbc_pkg::AxisW-1:0]       plane_word;
  logic signed [fbc_pkg::DataW-1:0] plane_rd;
  logic signed [fbc_pkg::DataW-1:0] corner_rd;
  logic signed [fbc_pkg::ExtW-1:0]  opa_sel;
  logic signed [fbc_pkg::ExtW-1:0]  opb;
  logic signed [fbc_pkg::DataW-1:0] opa;
  logic                             ab, bl;

  localparam logic [fbc_pkg::AxisW-1:0] LastAxis   = fbc_pkg::AxisW'(fbc_pkg::NumAxes - 1);
  localparam logic [fbc_pkg::IdxW-1:0]  LastPlane  = fbc_pkg::IdxW'(fbc_pkg::NumPlanes - 1);
  localparam logic [fbc_pkg::IdxW-1:0]  LastCorner = fbc_pkg::IdxW'(fbc_pkg::NumCorners - 1);
  localparam logic [fbc_pkg::AxisW-1:0] OffWord    = fbc_pkg::AxisW'(fbc_pkg::PlaneWords - 1);

  assign in_stall_o = (state_q != fbc_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign test_acc   = accept && (operation_i == fbc_pkg::OP_TEST_BOX);

  assign wr.plane_we  = accept && (operation_i == fbc_pkg::OP_WRITE_PLANE) &&
                        (entry_index_i <= LastPlane);
  assign wr.corner_we = accept && (operation_i == fbc_pkg::OP_WRITE_CORNER);
  assign wr.idx       = entry_index_i;

  assign plane_word = (state_q == fbc_pkg::ST_PINIT) ? OffWord : a_q;

  fbc_tables u_tables (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wr_i          (wr),
    .wx_i          (x_value_i),
    .wy_i          (y_value_i),
    .wz_i          (z_value_i),
    .woff_i        (plane_offset_i),
    .plane_idx_i   (p_q),
    .plane_word_i  (plane_word),
    .corner_idx_i  (c_q),
    .corner_axis_i (a_q),
    .plane_rd_o    (plane_rd),
    .corner_rd_o   (corner_rd)
  );

  assign opa = (state_q == fbc_pkg::ST_AXIS) ? corner_rd : plane_rd;
  assign opb = (state_q == fbc_pkg::ST_AXIS) ? pmx_q[a_q] :
               (sel_q ? pmx_q[a_q] : pmn_q[a_q]);
  assign opa_sel = pmn_q[a_q];

  fbc_alu u_alu (
    .clk_i  (clk_i),
    .ctrl_i (alu_ctrl),
    .opa_i  (opa),
    .opb_i  (opb),
    .opc_i  (opa_sel),
    .stat_o (alu_stat)
  );

  // box corners relative to world, one face pair per axis
  always_ff @(posedge clk_i) begin
    if (test_acc) begin
      pmn_q[0] <= {x_value_i[fbc_pkg::DataW-1], x_value_i} + {min_x_i[fbc_pkg::DataW-1], min_x_i};
      pmn_q[1] <= {y_value_i[fbc_pkg::DataW-1], y_value_i} + {min_y_i[fbc_pkg::DataW-1], min_y_i};
      pmn_q[2] <= {z_value_i[fbc_pkg::DataW-1], z_value_i} + {min_z_i[fbc_pkg::DataW-1], min_z_i};
      pmx_q[0] <= {x_value_i[fbc_pkg::DataW-1], x_value_i} + {max_x_i[fbc_pkg::DataW-1], max_x_i};
      pmx_q[1] <= {y_value_i[fbc_pkg::DataW-1], y_value_i} + {max_y_i[fbc_pkg::DataW-1], max_y_i};
      pmx_q[2] <= {z_value_i[fbc_pkg::DataW-1], z_value_i} + {max_z_i[fbc_pkg::DataW-1], max_z_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fbc_pkg::ST_IDLE;
      p_q     <= '0;
      c_q     <= '0;
      a_q     <= '0;
      sel_q   <= 1'b0;
      above_q <= 1'b1;
      below_q <= 1'b1;
      kind_q  <= fbc_pkg::KIND_NONE;
    end else begin
      state_q <= state_d;
      p_q     <= p_d;
      c_q     <= c_d;
      a_q     <= a_d;
      sel_q   <= sel_d;
      above_q <= above_d;
      below_q <= below_d;
      kind_q  <= kind_d;
    end
  end

  assign ab = above_q && alu_stat.above;
  assign bl = below_q && alu_stat.below;

  always_comb begin
    state_d      = state_q;
    p_d          = p_q;
    c_d          = c_q;
    a_d          = a_q;
    sel_d        = sel_q;
    above_d      = above_q;
    below_d      = below_q;
    kind_d       = kind_q;
    alu_ctrl.op  = fbc_pkg::ALU_HOLD;
    post         = 1'b0;
    unique case (state_q)
      fbc_pkg::ST_IDLE: begin
        if (test_acc) begin
          p_d     = '0;
          state_d = fbc_pkg::ST_PINIT;
        end
      end
      fbc_pkg::ST_PINIT: begin
        alu_ctrl.op = fbc_pkg::ALU_OFFSET;
        a_d         = '0;
        sel_d       = 1'b0;
        state_d     = fbc_pkg::ST_MUL;
      end
      fbc_pkg::ST_MUL: begin
        alu_ctrl.op = fbc_pkg::ALU_MUL;
        state_d     = fbc_pkg::ST_ACC;
      end
      fbc_pkg::ST_ACC: begin
        if (sel_q) begin
          alu_ctrl.op = fbc_pkg::ALU_ACC;
          if (a_q == LastAxis) begin
            state_d = fbc_pkg::ST_PCHK;
          end else begin
            a_d     = a_q + 1'b1;
            sel_d   = 1'b0;
            state_d = fbc_pkg::ST_MUL;
          end
        end else begin
          alu_ctrl.op = fbc_pkg::ALU_KEEP;
          sel_d       = 1'b1;
          state_d     = fbc_pkg::ST_MUL;
        end
      end
      fbc_pkg::ST_PCHK: begin
        priority if (alu_stat.acc_neg) begin
          kind_d  = fbc_pkg::KIND_PLANE;
          state_d = fbc_pkg::ST_DONE;
        end else if (p_q == LastPlane) begin
          a_d     = '0;
          c_d     = '0;
          above_d = 1'b1;
          below_d = 1'b1;
          state_d = fbc_pkg::ST_AXIS;
        end else begin
          p_d     = p_q + 1'b1;
          state_d = fbc_pkg::ST_PINIT;
        end
      end
      fbc_pkg::ST_AXIS: begin
        if (c_q == LastCorner) begin
          priority if (ab || bl) begin
            kind_d  = fbc_pkg::KIND_AXIS;
            state_d = fbc_pkg::ST_DONE;
          end else if (a_q == LastAxis) begin
            kind_d  = fbc_pkg::KIND_NONE;
            state_d = fbc_pkg::ST_DONE;
          end else begin
            a_d     = a_q + 1'b1;
            c_d     = '0;
            above_d = 1'b1;
            below_d = 1'b1;
          end
        end else begin
          c_d     = c_q + 1'b1;
          above_d = ab;
          below_d = bl;
        end
      end
      fbc_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          post    = 1'b1;
          state_d = fbc_pkg::ST_IDLE;
        end
      end
      default: state_d = fbc_pkg::ST_IDLE;
    endcase
  end

  // result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (post) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (post) begin
      visible_q  <= (kind_q == fbc_pkg::KIND_NONE);
      out_kind_q <= kind_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign visible_o     = visible_q;
  assign reject_kind_o = out_kind_q;

  a_busy_after_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    test_acc |=> in_stall_o && (state_q == fbc_pkg::ST_PINIT))
    else $error("box test not started");

  a_write_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (operation_i != fbc_pkg::OP_TEST_BOX) |=> !in_stall_o)
    else $error("table write left block busy");

  a_word_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (visible_o == (reject_kind_o == fbc_pkg::KIND_NONE)))
    else $error("visible flag disagrees with reject kind");

  a_plane_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_q <= LastPlane)
    else $error("plane counter out of range");

  a_post_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    post |-> (!out_valid_q || !out_stall_i))
    else $error("result word overwritten while stalled");

endmodule

`default_nettype wire
